// ===== design/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Port item layouts, root kind codes and default sizes.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_W          = 16;
  localparam int OUT_W           = 40;
  localparam int DEF_COEF_BITS   = 16;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_DISTINCT = 2'd0;
  localparam logic [1:0] KIND_REPEATED = 2'd1;
  localparam logic [1:0] KIND_COMPLEX  = 2'd2;
  localparam logic [1:0] KIND_DEGEN    = 2'd3;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_quad;
    logic signed [COEF_W-1:0] coef_lin;
    logic signed [COEF_W-1:0] coef_const;
  } coef_item_t;

  typedef struct packed {
    logic [1:0]              root_kind;
    logic signed [OUT_W-1:0] first_value;
    logic signed [OUT_W-1:0] second_value;
  } root_item_t;

endpackage

// ===== design/qrs_queue.sv =====
// ----------------------------------------------------------------------------
// qrs_queue: small FIFO between classifier and solver pipeline
// Flop-based ring buffer; the head entry is read combinationally.
// ----------------------------------------------------------------------------
module qrs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             nonempty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !nonempty))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue fill count out of range");

endmodule

// ===== design/qrs_front.sv =====
// ----------------------------------------------------------------------------
// qrs_front: coefficient intake and root classification
// Forms b*b and a*c, then the discriminant, the root kind, -b scaled and 2a.
// ----------------------------------------------------------------------------
module qrs_front #(
  parameter int COEF_BITS = 16,
  parameter int FRAC_BITS = 16,
  parameter int ENTRY_W   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                coef_valid,
  output logic                coef_stall,
  input  qrs_pkg::coef_item_t coef,
  output logic                push,
  output logic [ENTRY_W-1:0]  entry,
  input  logic                full
);
  import qrs_pkg::*;

  localparam int CB  = COEF_BITS;
  localparam int MW  = 2 * CB + 2;
  localparam int NW  = CB + FRAC_BITS + 3;
  localparam int DMW = CB + 1;

  typedef struct packed {
    logic [1:0]           kind;
    logic [MW-1:0]        mag;
    logic signed [NW-1:0] nb;
    logic                 den_neg;
    logic [DMW-1:0]       den_mag;
  } entry_t;

  logic signed [CB-1:0]   a_s;
  logic signed [CB-1:0]   b_s;
  logic signed [CB-1:0]   c_s;
  logic                   p1_valid;
  logic signed [CB-1:0]   p1_a;
  logic signed [CB-1:0]   p1_b;
  logic signed [2*CB-1:0] p1_bb;
  logic signed [2*CB-1:0] p1_ac;
  logic                   p2_valid;
  entry_t                 p2_entry;
  entry_t                 p2_next;
  logic                   adv;
  logic signed [MW-1:0]   disc;
  logic signed [DMW-1:0]  a_ext;
  logic signed [DMW-1:0]  a_abs;
  logic                   a_zero;

  // Coefficients wider than the port field take the field zero extended.
  if (CB > COEF_W) begin : g_wide
    assign a_s = signed'({{(CB - COEF_W){1'b0}}, coef.coef_quad});
    assign b_s = signed'({{(CB - COEF_W){1'b0}}, coef.coef_lin});
    assign c_s = signed'({{(CB - COEF_W){1'b0}}, coef.coef_const});
  end else begin : g_narrow
    assign a_s = coef.coef_quad[CB-1:0];
    assign b_s = coef.coef_lin[CB-1:0];
    assign c_s = coef.coef_const[CB-1:0];
  end

  // hold both stages while the queue cannot take the classified item
  assign adv        = !(p2_valid && full);
  assign coef_stall = !adv;
  assign push       = p2_valid && !full;
  assign entry      = p2_entry;

  always_comb begin
    disc   = MW'(p1_bb) - (MW'(p1_ac) <<< 2);
    a_zero = (p1_a == '0);
    a_ext  = DMW'(p1_a);
    a_abs  = (a_ext < 0) ? -a_ext : a_ext;
    p2_next.mag     = (disc < 0) ? MW'(-disc) : MW'(disc);
    p2_next.den_neg = p1_a[CB-1];
    if (a_zero) begin
      p2_next.kind    = KIND_DEGEN;
      p2_next.nb      = '0;
      p2_next.den_mag = DMW'(2);
    end else begin
      if (disc > 0) begin
        p2_next.kind = KIND_DISTINCT;
      end else if (disc == 0) begin
        p2_next.kind = KIND_REPEATED;
      end else begin
        p2_next.kind = KIND_COMPLEX;
      end
      p2_next.nb      = (-(NW'(p1_b))) <<< FRAC_BITS;
      p2_next.den_mag = DMW'(a_abs) << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= coef_valid;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_a     <= a_s;
      p1_b     <= b_s;
      p1_bb    <= b_s * b_s;
      p1_ac    <= a_s * c_s;
      p2_entry <= p2_next;
    end
  end

endmodule

// ===== design/qrs_divider.sv =====
// ----------------------------------------------------------------------------
// qrs_divider: pipelined restoring divider, truncating toward zero
// One quotient bit per stage; returns magnitude and sign of the quotient.
// ----------------------------------------------------------------------------
module qrs_divider #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 17
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic                    den_neg,
  input  logic [DEN_W-1:0]        den_mag,
  output logic [NUM_W-2:0]        quo_mag,
  output logic                    quo_neg
);
  localparam int QW = NUM_W - 1;
  localparam int RW = DEN_W + 1;

  logic [QW-1:0]      n_sh [0:QW];
  logic [RW-1:0]      rem  [0:QW];
  logic [QW-1:0]      quo  [0:QW];
  logic [DEN_W-1:0]   dv   [0:QW];
  logic               neg  [0:QW];
  logic signed [NUM_W-1:0] num_abs;

  assign num_abs = (num < 0) ? -num : num;

  always_ff @(posedge clk) begin
    if (en) begin
      n_sh[0] <= num_abs[QW-1:0];
      rem[0]  <= '0;
      quo[0]  <= '0;
      dv[0]   <= den_mag;
      neg[0]  <= num[NUM_W-1] ^ den_neg;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RW-1:0] rem_sh;
    logic          ge;
    assign rem_sh = {rem[k][RW-2:0], n_sh[k][QW-1]};
    assign ge     = (rem_sh >= {1'b0, dv[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? rem_sh - {1'b0, dv[k]} : rem_sh;
        n_sh[k+1] <= n_sh[k] << 1;
        quo[k+1]  <= {quo[k][QW-2:0], ge};
        dv[k+1]   <= dv[k];
        neg[k+1]  <= neg[k];
      end
    end
  end

  assign quo_mag = quo[QW];
  assign quo_neg = neg[QW];

endmodule

// ===== design/qrs_back.sv =====
// ----------------------------------------------------------------------------
// qrs_back: square root, numerators, divisions and result register
// Pipelined digit-by-digit square root, then two dividers by 2a.
// ----------------------------------------------------------------------------
module qrs_back #(
  parameter int COEF_BITS = 16,
  parameter int FRAC_BITS = 16,
  parameter int ENTRY_W   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_nonempty,
  input  logic [ENTRY_W-1:0]  q_entry,
  output logic                pop,
  output logic                root_valid,
  input  logic                root_stall,
  output qrs_pkg::root_item_t root
);
  import qrs_pkg::*;

  localparam int CB  = COEF_BITS;
  localparam int MW  = 2 * CB + 2;
  localparam int NW  = CB + FRAC_BITS + 3;
  localparam int DMW = CB + 1;
  localparam int P   = CB + 1 + FRAC_BITS;
  localparam int RW  = P + 2;
  localparam int QW  = NW - 1;
  localparam int XW  = (QW + 1 > OUT_W) ? QW + 1 : OUT_W + 1;
  localparam logic signed [XW-1:0] SAT_HI = XW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

  typedef struct packed {
    logic [1:0]           kind;
    logic [MW-1:0]        mag;
    logic signed [NW-1:0] nb;
    logic                 den_neg;
    logic [DMW-1:0]       den_mag;
  } entry_t;

  logic                 en;
  logic                 sq_valid [0:P];
  entry_t               sq_ent   [0:P];
  logic [RW-1:0]        sq_rem   [0:P];
  logic [P-1:0]         sq_root  [0:P];
  logic                 nm_valid;
  logic [1:0]           nm_kind;
  logic signed [NW-1:0] nm_num1;
  logic signed [NW-1:0] nm_num2;
  logic                 nm_den_neg;
  logic [DMW-1:0]       nm_den_mag;
  logic signed [NW-1:0] s_ext;
  logic                 dv_valid [0:QW];
  logic [1:0]           dv_kind  [0:QW];
  logic [QW-1:0]        q1_mag;
  logic [QW-1:0]        q2_mag;
  logic                 q1_neg;
  logic                 q2_neg;
  logic signed [XW-1:0] v1;
  logic signed [XW-1:0] v2;
  logic signed [OUT_W-1:0] v1_sat;
  logic signed [OUT_W-1:0] v2_sat;

  // the whole pipeline moves together whenever the result register is free
  assign en  = !root_valid || !root_stall;
  assign pop = en && q_nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (en) begin
      sq_valid[0] <= q_nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_ent[0]  <= q_entry;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  for (genvar g = 0; g < P; g++) begin : g_sqrt
    logic [1:0]    pair;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;
    if (CB - g >= 0) begin : g_pair
      assign pair = sq_ent[g].mag[2*(CB-g)+1 -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end
    assign rem_sh = {sq_rem[g][RW-3:0], pair};
    assign trial  = {sq_root[g], 2'b01};
    assign ge     = (rem_sh >= trial);
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[g+1] <= 1'b0;
      end else if (en) begin
        sq_valid[g+1] <= sq_valid[g];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_ent[g+1]  <= sq_ent[g];
        sq_rem[g+1]  <= ge ? rem_sh - trial : rem_sh;
        sq_root[g+1] <= {sq_root[g][P-2:0], ge};
      end
    end
  end

  assign s_ext = signed'({2'b00, sq_root[P]});

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_valid <= 1'b0;
    end else if (en) begin
      nm_valid <= sq_valid[P];
    end
  end

  // pick numerators by kind; repeated and degenerate leave the second at zero
  always_ff @(posedge clk) begin
    if (en) begin
      nm_kind    <= sq_ent[P].kind;
      nm_den_neg <= sq_ent[P].den_neg;
      nm_den_mag <= sq_ent[P].den_mag;
      case (sq_ent[P].kind)
        KIND_DISTINCT: begin
          nm_num1 <= sq_ent[P].nb + s_ext;
          nm_num2 <= sq_ent[P].nb - s_ext;
        end
        KIND_COMPLEX: begin
          nm_num1 <= sq_ent[P].nb;
          nm_num2 <= s_ext;
        end
        default: begin
          nm_num1 <= sq_ent[P].nb;
          nm_num2 <= '0;
        end
      endcase
    end
  end

  qrs_divider #(.NUM_W(NW), .DEN_W(DMW)) u_div_first (
    .clk     (clk),
    .en      (en),
    .num     (nm_num1),
    .den_neg (nm_den_neg),
    .den_mag (nm_den_mag),
    .quo_mag (q1_mag),
    .quo_neg (q1_neg)
  );

  qrs_divider #(.NUM_W(NW), .DEN_W(DMW)) u_div_second (
    .clk     (clk),
    .en      (en),
    .num     (nm_num2),
    .den_neg (nm_den_neg),
    .den_mag (nm_den_mag),
    .quo_mag (q2_mag),
    .quo_neg (q2_neg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= nm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_kind[0] <= nm_kind;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_line
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (en) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_kind[k+1] <= dv_kind[k];
      end
    end
  end

  always_comb begin
    v1 = q1_neg ? -XW'(q1_mag) : XW'(q1_mag);
    v2 = q2_neg ? -XW'(q2_mag) : XW'(q2_mag);
    if (v1 > SAT_HI) begin
      v1_sat = OUT_W'(SAT_HI);
    end else if (v1 < SAT_LO) begin
      v1_sat = OUT_W'(SAT_LO);
    end else begin
      v1_sat = v1[OUT_W-1:0];
    end
    if (v2 > SAT_HI) begin
      v2_sat = OUT_W'(SAT_HI);
    end else if (v2 < SAT_LO) begin
      v2_sat = OUT_W'(SAT_LO);
    end else begin
      v2_sat = v2[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (en) begin
      root_valid <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root.root_kind    <= dv_kind[QW];
      root.first_value  <= v1_sat;
      root.second_value <= v2_sat;
    end
  end

endmodule

// ===== design/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver: fixed-point roots of a*x^2 + b*x + c
// Classifies the discriminant and returns real roots or real and imaginary
// parts with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// One coefficient set is taken per cycle and one result leaves per cycle when
// neither side stalls. Most of the path from an input transfer to its result
// lies in the square root pipeline (one root bit per stage,
// COEF_BITS+FRAC_BITS+1 stages) and the two dividers (one quotient bit per
// stage, COEF_BITS+FRAC_BITS+2 stages). The front stages form b*b, a*c, the
// discriminant and the root kind and hand items through a QUEUE_DEPTH-entry
// queue to the back pipeline, so a stall on the result side holds the back
// pipeline while the front keeps filling the queue. root_kind: 0 two real
// roots, 1 repeated root (second value zero), 2 complex pair (real part,
// imaginary part with the sign of a), 3 zero quadratic coefficient (both
// values zero). Square roots are floored, divisions truncate toward zero,
// values beyond 40 bits saturate.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
  parameter int COEF_BITS   = qrs_pkg::DEF_COEF_BITS,
  parameter int FRAC_BITS   = qrs_pkg::DEF_FRAC_BITS,
  parameter int QUEUE_DEPTH = qrs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                coef_valid,
  output logic                coef_stall,
  input  qrs_pkg::coef_item_t coef,
  output logic                root_valid,
  input  logic                root_stall,
  output qrs_pkg::root_item_t root
);
  import qrs_pkg::*;

  localparam int CB      = COEF_BITS;
  localparam int ENTRY_W = 2 + (2 * CB + 2) + (CB + FRAC_BITS + 3) + 1 + (CB + 1);

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_nonempty;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;

  // classify and push
  qrs_front #(.COEF_BITS(COEF_BITS), .FRAC_BITS(FRAC_BITS), .ENTRY_W(ENTRY_W)) u_front (
    .clk        (clk),
    .rst        (rst),
    .coef_valid (coef_valid),
    .coef_stall (coef_stall),
    .coef       (coef),
    .push       (q_push),
    .entry      (q_wdata),
    .full       (q_full)
  );

  // decouple the two halves
  qrs_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .nonempty (q_nonempty)
  );

  // solve and present
  qrs_back #(.COEF_BITS(COEF_BITS), .FRAC_BITS(FRAC_BITS), .ENTRY_W(ENTRY_W)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_entry    (q_rdata),
    .pop        (q_pop),
    .root_valid (root_valid),
    .root_stall (root_stall),
    .root       (root)
  );

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
      (root_valid && root.root_kind == KIND_DEGEN) |->
      (root.first_value == '0 && root.second_value == '0))
    else $error("degenerate result carries non-zero values");
  a_repeated_second: assert property (@(posedge clk) disable iff (rst)
      (root_valid && root.root_kind == KIND_REPEATED) |-> (root.second_value == '0))
    else $error("repeated root with non-zero second value");
  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
      (root_valid && root_stall) |=> (root_valid && $stable(root)))
    else $error("stalled result changed");

endmodule
